[hdl/assert_macros.svh]
// ------------------------------------------------------------------------
// assertion macros
// clocked property checks with an active-low reset guard
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

[hdl/ubx_fp_pkg.sv]
// ------------------------------------------------------------------------
// ubx_fp_pkg
// shared types and register codes of the ubx frame parser
// ------------------------------------------------------------------------
package ubx_fp_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_CLASS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CAPTURE_ID    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_CAPTURE_ID   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CAPTURE_SIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_CAPTURE_SIZE = 3'd4;

    // reset values
    localparam logic [7:0]  RST_CAPTURE_CLASS       = 8'd1;
    localparam logic [7:0]  RST_FIRST_CAPTURE_ID    = 8'd7;
    localparam logic [7:0]  RST_SECOND_CAPTURE_ID   = 8'd54;
    localparam logic [15:0] RST_FIRST_CAPTURE_SIZE  = 16'd92;
    localparam logic [15:0] RST_SECOND_CAPTURE_SIZE = 16'd64;

    typedef struct packed {
        logic [7:0]  capture_class;
        logic [7:0]  first_capture_id;
        logic [7:0]  second_capture_id;
        logic [15:0] first_capture_size;
        logic [15:0] second_capture_size;
    } t_cfg;

    typedef struct packed {
        logic        write_valid;
        logic        write_target;
        logic [15:0] write_offset;
        logic [7:0]  write_data;
        logic        frame_done;
        logic        frame_good;
        logic        commit;
        logic        commit_target;
        logic [7:0]  frame_class;
        logic [7:0]  frame_id;
    } t_result;

endpackage

[hdl/ubx_fp_cfg.sv]
// ------------------------------------------------------------------------
// ubx_fp_cfg
// capture configuration registers, written through the config channel
// ------------------------------------------------------------------------
module ubx_fp_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [ubx_fp_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  logic [15:0]                      i_wr_data,
    output ubx_fp_pkg::t_cfg                 o_cfg
);

    ubx_fp_pkg::t_cfg r_cfg;
    ubx_fp_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                ubx_fp_pkg::CFG_CAPTURE_CLASS:       n_cfg.capture_class       = i_wr_data[7:0];
                ubx_fp_pkg::CFG_FIRST_CAPTURE_ID:    n_cfg.first_capture_id    = i_wr_data[7:0];
                ubx_fp_pkg::CFG_SECOND_CAPTURE_ID:   n_cfg.second_capture_id   = i_wr_data[7:0];
                ubx_fp_pkg::CFG_FIRST_CAPTURE_SIZE:  n_cfg.first_capture_size  = i_wr_data;
                ubx_fp_pkg::CFG_SECOND_CAPTURE_SIZE: n_cfg.second_capture_size = i_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capture_class       <= ubx_fp_pkg::RST_CAPTURE_CLASS;
            r_cfg.first_capture_id    <= ubx_fp_pkg::RST_FIRST_CAPTURE_ID;
            r_cfg.second_capture_id   <= ubx_fp_pkg::RST_SECOND_CAPTURE_ID;
            r_cfg.first_capture_size  <= ubx_fp_pkg::RST_FIRST_CAPTURE_SIZE;
            r_cfg.second_capture_size <= ubx_fp_pkg::RST_SECOND_CAPTURE_SIZE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/ubx_fp_parser.sv]
// ------------------------------------------------------------------------
// ubx_fp_parser
// frame state, fletcher-8 sums and per-byte result decode
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module ubx_fp_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_byte,
    input  ubx_fp_pkg::t_cfg    i_cfg,
    output ubx_fp_pkg::t_result o_res
);

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'b001,
        PH_PAYLOAD  = 3'b010,
        PH_CHECKSUM = 3'b100
    } t_phase;

    t_phase      r_phase,    n_phase;
    logic [16:0] r_position, n_position;
    logic [7:0]  r_sum_a,    n_sum_a;
    logic [7:0]  r_sum_b,    n_sum_b;
    logic [7:0]  r_rx_sum_a, n_rx_sum_a;
    logic [7:0]  r_class,    n_class;
    logic [7:0]  r_id,       n_id;
    logic [15:0] r_length,   n_length;

    ubx_fp_pkg::t_result res;

    logic [7:0]  acc_a;
    logic [7:0]  acc_b;
    logic [16:0] pos_inc;
    logic [16:0] frame_end;
    logic [15:0] offset;
    logic        class_hit;
    logic        hit_first;
    logic        hit_second;
    logic        good;

    assign acc_a      = r_sum_a + i_byte;
    assign acc_b      = r_sum_b + acc_a;
    assign pos_inc    = r_position + 17'd1;
    assign frame_end  = {1'b0, r_length} + 17'd6;
    assign offset     = r_position[15:0] - 16'd6;
    assign class_hit  = (r_class == i_cfg.capture_class);
    // first id wins when both ids are the same
    assign hit_first  = class_hit && (r_id == i_cfg.first_capture_id);
    assign hit_second = class_hit && !hit_first && (r_id == i_cfg.second_capture_id);
    assign good       = (r_rx_sum_a == r_sum_a) && (i_byte == r_sum_b);

    always_comb begin
        n_phase    = r_phase;
        n_position = r_position;
        n_sum_a    = r_sum_a;
        n_sum_b    = r_sum_b;
        n_rx_sum_a = r_rx_sum_a;
        n_class    = r_class;
        n_id       = r_id;
        n_length   = r_length;
        res        = '0;

        unique case (r_phase)
            PH_HEADER: begin
                unique case (r_position)
                    17'd0: n_position = (i_byte == SYNC_FIRST) ? 17'd1 : 17'd0;
                    17'd1: begin
                        if (i_byte == SYNC_SECOND) begin
                            n_position = 17'd2;
                        end else begin
                            n_position = (i_byte == SYNC_FIRST) ? 17'd1 : 17'd0;
                        end
                    end
                    17'd2: begin
                        n_sum_a    = acc_a;
                        n_sum_b    = acc_b;
                        n_class    = i_byte;
                        n_position = 17'd3;
                    end
                    17'd3: begin
                        n_sum_a    = acc_a;
                        n_sum_b    = acc_b;
                        n_id       = i_byte;
                        n_position = 17'd4;
                    end
                    17'd4: begin
                        n_sum_a    = acc_a;
                        n_sum_b    = acc_b;
                        n_length   = {8'd0, i_byte};
                        n_position = 17'd5;
                    end
                    17'd5: begin
                        n_sum_a    = acc_a;
                        n_sum_b    = acc_b;
                        n_length   = {i_byte, r_length[7:0]};
                        n_position = 17'd6;
                        // empty payload goes straight to the checksum
                        n_phase    = ({i_byte, r_length[7:0]} == 16'd0) ? PH_CHECKSUM
                                                                          : PH_PAYLOAD;
                    end
                    default: begin
                        n_phase    = PH_HEADER;
                        n_position = '0;
                        n_sum_a    = '0;
                        n_sum_b    = '0;
                    end
                endcase
            end
            PH_PAYLOAD: begin
                n_sum_a    = acc_a;
                n_sum_b    = acc_b;
                n_position = pos_inc;
                if (pos_inc >= frame_end) begin
                    n_phase = PH_CHECKSUM;
                end
                if (hit_first && (offset < i_cfg.first_capture_size)) begin
                    res.write_valid  = 1'b1;
                    res.write_target = 1'b0;
                    res.write_offset = offset;
                    res.write_data   = i_byte;
                end else if (hit_second && (offset < i_cfg.second_capture_size)) begin
                    res.write_valid  = 1'b1;
                    res.write_target = 1'b1;
                    res.write_offset = offset;
                    res.write_data   = i_byte;
                end
            end
            PH_CHECKSUM: begin
                if (r_position == frame_end) begin
                    n_rx_sum_a = i_byte;
                    n_position = pos_inc;
                end else begin
                    res.frame_done    = 1'b1;
                    res.frame_good    = good;
                    res.commit        = good && (hit_first || hit_second);
                    res.commit_target = good && hit_second;
                    n_phase           = PH_HEADER;
                    n_position        = '0;
                    n_sum_a           = '0;
                    n_sum_b           = '0;
                end
            end
            default: begin
                n_phase    = PH_HEADER;
                n_position = '0;
                n_sum_a    = '0;
                n_sum_b    = '0;
            end
        endcase

        res.frame_class = n_class;
        res.frame_id    = n_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_position <= '0;
            r_sum_a    <= '0;
            r_sum_b    <= '0;
            r_rx_sum_a <= '0;
            r_class    <= '0;
            r_id       <= '0;
            r_length   <= '0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_position <= n_position;
            r_sum_a    <= n_sum_a;
            r_sum_b    <= n_sum_b;
            r_rx_sum_a <= n_rx_sum_a;
            r_class    <= n_class;
            r_id       <= n_id;
            r_length   <= n_length;
        end
    end

    assign o_res = res;

    `ASSERT_NEVER(a_write_and_done, i_clk, i_rst_n, res.write_valid && res.frame_done, "payload write on a checksum word")
    `ASSERT_CLK(a_commit_needs_good, i_clk, i_rst_n, res.commit |-> (res.frame_done && res.frame_good), "commit without a good frame")
    `ASSERT_CLK(a_done_restarts, i_clk, i_rst_n, (i_en && res.frame_done) |=> (r_phase == PH_HEADER && r_position == 17'd0 && r_sum_a == 8'd0 && r_sum_b == 8'd0), "hunt not restarted after frame end")
    `ASSERT_CLK(a_payload_in_range, i_clk, i_rst_n, (r_phase == PH_PAYLOAD) |-> (r_position >= 17'd6 && r_position < frame_end), "payload position outside frame")

endmodule

[hdl/ubx_frame_parser_core.sv]
// ------------------------------------------------------------------------
// ubx_frame_parser_core
// ubx frame parser with fletcher-8 check and payload capture
// ------------------------------------------------------------------------
// Takes one received byte per cycle while the master side accepts results
// and gives exactly one result word per byte on the master side, through
// one input register and one result register around the single-pass
// parser logic. The input side stays ready while a finished result waits,
// until both registers are full.
// Capture registers are written on the cfg channel, which is always ready;
// write them only while no byte is in flight. Result flags travel in
// tuser; a payload byte of a captured message appears as write_valid with
// target and offset, and frame_done marks the second checksum byte.
`include "assert_macros.svh"

module ubx_frame_parser_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [7:0]                       i_s_tdata,   // [7:0] rx_byte
    // master stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [0] write_target, [16:1] write_offset, [24:17] write_data,
    // [25] frame_good, [26] commit, [27] commit_target,
    // [35:28] frame_class, [43:36] frame_id, [47:44] zero
    output logic [47:0]                      o_m_tdata,
    output logic [1:0]                       o_m_tuser,   // [0] write_valid, [1] frame_done
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ubx_fp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                      i_cfg_data
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_out_valid;
    ubx_fp_pkg::t_result r_out;

    ubx_fp_pkg::t_cfg    cfg;
    ubx_fp_pkg::t_result res;
    logic                advance;
    logic                step;

    assign o_cfg_ready = 1'b1;
    assign advance     = !r_out_valid || i_m_tready;
    assign o_s_tready  = !r_in_valid || advance;
    assign step        = r_in_valid && advance;

    ubx_fp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    ubx_fp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (step),
        .i_byte  (r_in_byte),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
        if (step) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = {r_out.frame_done, r_out.write_valid};
    assign o_m_tdata  = {4'd0,
                         r_out.frame_id,
                         r_out.frame_class,
                         r_out.commit_target,
                         r_out.commit,
                         r_out.frame_good,
                         r_out.write_data,
                         r_out.write_offset,
                         r_out.write_target};

    `ASSERT_CLK(a_stall_only_when_full, i_clk, i_rst_n, !o_s_tready |-> (r_in_valid && r_out_valid && !i_m_tready), "input stalled with room in the pipe")
    `ASSERT_CLK(a_word_reaches_output, i_clk, i_rst_n, step |=> o_m_tvalid, "parsed word lost before the output")

endmodule
